FILE: design/bvm_pkg.sv
// ----------------------------------------------------------------------------
// bvm_pkg
// Shared types and constants of the byte-code VM executor.
// ----------------------------------------------------------------------------
package bvm_pkg;

  localparam int MEM_BYTES_D     = 4096;
  localparam int STACK_DEPTH_D   = 16;
  localparam int SCREEN_WIDTH_D  = 64;
  localparam int SCREEN_HEIGHT_D = 32;

  localparam logic [11:0] PC_START = 12'h200;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_PIXEL = 2'd2;
  localparam logic [1:0] OP_EXEC  = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLEAR, ST_MREAD, ST_FETCH_HI, ST_FETCH_LO, ST_DECODE, ST_EXEC,
    ST_DRAW_RD, ST_DRAW_LINE, ST_DRAW_PIX, ST_DRAW_WR,
    ST_SCLR, ST_BCD, ST_DUMP, ST_LOAD_RD, ST_LOAD_WR, ST_PX_RD, ST_DONE
  } state_t;

  typedef struct packed {
    logic       drawn;
    logic       waiting;
    logic       fault;
  } flags_t;

endpackage

FILE: design/byte_vm_instruction_executor_top.sv
// ----------------------------------------------------------------------------
// byte_vm_instruction_executor_top
// Iterative executor of the 35-opcode byte-code VM instruction set.
// ----------------------------------------------------------------------------
// After reset a clearing pass zeroes memory and screen in parallel before the
// first request is taken. A request occupies the block until its result is
// delivered. Memory writes go straight to the done state; memory and pixel
// reads pass through a read state. Instructions fetch the high and the low
// byte, decode and execute; 00E0 then clears every pixel, FX33 writes three
// digits, FX55 stores V0 to VX, FX65 reads and writes each of V0 to VX, and
// DXYN reads each sprite row, then for an on-screen row visits each pixel and
// writes back every set on-screen one. This is set by the single memory port
// and single screen port walked by one sequencer.
module byte_vm_instruction_executor_top #(
  parameter int MEM_BYTES     = bvm_pkg::MEM_BYTES_D,
  parameter int STACK_DEPTH   = bvm_pkg::STACK_DEPTH_D,
  parameter int SCREEN_WIDTH  = bvm_pkg::SCREEN_WIDTH_D,
  parameter int SCREEN_HEIGHT = bvm_pkg::SCREEN_HEIGHT_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [4:0]  in_key_code,
  input  logic [7:0]  in_random_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_program_counter,
  output logic [7:0]  out_read_data,
  output logic        out_screen_drawn,
  output logic        out_awaiting_key,
  output logic        out_stack_fault
);
  import bvm_pkg::*;

  localparam int AW    = $clog2(MEM_BYTES);
  localparam int PIX   = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int PW    = $clog2(PIX);
  localparam int SPW   = $clog2(STACK_DEPTH + 1);
  localparam int SIW   = $clog2(STACK_DEPTH);
  localparam int CLR_N = (MEM_BYTES > PIX) ? MEM_BYTES : PIX;
  localparam int CW    = $clog2(CLR_N);

  state_t state_r, state_nxt;

  logic [11:0] addr_r;
  logic [7:0]  rnd_r;
  logic [4:0]  key_r;
  logic [7:0]  v_r [16];
  logic [11:0] stk_r [STACK_DEPTH];
  logic [SPW-1:0] sp_r;
  logic [11:0] pc_r;
  logic [15:0] i_r;
  logic [7:0]  dt_r, st_r;
  logic [7:0]  hi_r, lo_r;
  logic [7:0]  rd_r;
  flags_t      fl_r;
  logic [CW-1:0] cnt_r;
  logic [3:0]  k_r;
  logic [7:0]  x0_r, y0_r, line_r;
  logic [2:0]  c_r;
  logic [PW-1:0] pidx_r;
  logic        ovalid_r;

  logic          m_we;
  logic [AW-1:0] m_addr;
  logic [7:0]    m_wd, m_rd;
  logic          s_we;
  logic [PW-1:0] s_addr;
  logic          s_wd, s_rd;
  logic [PIX-1:0] scr_r;

  bvm_mem #(.DEPTH(MEM_BYTES), .WIDTH(8)) u_mem (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd)
  );

  always_ff @(posedge clk) begin
    if (s_we) scr_r[s_addr] <= s_wd;
    s_rd <= scr_r[s_addr];
  end

  wire [3:0] x_f = hi_r[3:0];
  wire [3:0] y_f = lo_r[7:4];
  wire [3:0] n_f = lo_r[3:0];
  wire [11:0] nnn = {x_f, lo_r};
  wire [7:0] va = v_r[x_f];
  wire [7:0] vb = v_r[y_f];
  wire key_ok = (key_r < 5'd16);
  wire [15:0] i_k = i_r + {12'd0, k_r};
  wire [8:0] py = {1'b0, y0_r} + {5'd0, k_r};
  wire [8:0] px = {1'b0, x0_r} + {6'd0, c_r};
  wire [15:0] pix_a = 16'(py) * 16'(SCREEN_WIDTH) + 16'(px);
  wire in_acc = in_valid && !in_stall;
  wire [7:0] bcd_h = (va >= 8'd200) ? 8'd2 : (va >= 8'd100) ? 8'd1 : 8'd0;
  wire [7:0] bcd_r = va - bcd_h * 8'd100;
  wire [7:0] bcd_t = (bcd_r >= 8'd90) ? 8'd9 : (bcd_r >= 8'd80) ? 8'd8 :
                     (bcd_r >= 8'd70) ? 8'd7 : (bcd_r >= 8'd60) ? 8'd6 :
                     (bcd_r >= 8'd50) ? 8'd5 : (bcd_r >= 8'd40) ? 8'd4 :
                     (bcd_r >= 8'd30) ? 8'd3 : (bcd_r >= 8'd20) ? 8'd2 :
                     (bcd_r >= 8'd10) ? 8'd1 : 8'd0;
  wire [7:0] bcd_o = bcd_r - bcd_t * 8'd10;

  assign in_stall  = (state_r != ST_IDLE) || ovalid_r;
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (cnt_r == CW'(CLR_N - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_acc) begin
        case (in_operation)
          OP_WRITE: state_nxt = ST_DONE;
          OP_READ:  state_nxt = ST_MREAD;
          OP_PIXEL: state_nxt = ST_PX_RD;
          default:  state_nxt = ST_FETCH_HI;
        endcase
      end
      ST_MREAD, ST_PX_RD: state_nxt = ST_DONE;
      ST_FETCH_HI:  state_nxt = ST_FETCH_LO;
      ST_FETCH_LO:  state_nxt = ST_DECODE;
      ST_DECODE:    state_nxt = ST_EXEC;
      ST_EXEC: begin
        state_nxt = ST_DONE;
        if (hi_r[7:4] == 4'h0 && x_f == 4'h0 && lo_r == 8'hE0) state_nxt = ST_SCLR;
        else if (hi_r[7:4] == 4'hD) state_nxt = (n_f == 4'd0) ? ST_DONE : ST_DRAW_RD;
        else if (hi_r[7:4] == 4'hF && lo_r == 8'h33) state_nxt = ST_BCD;
        else if (hi_r[7:4] == 4'hF && lo_r == 8'h55) state_nxt = ST_DUMP;
        else if (hi_r[7:4] == 4'hF && lo_r == 8'h65) state_nxt = ST_LOAD_RD;
      end
      ST_SCLR: if (pidx_r == PW'(PIX - 1)) state_nxt = ST_DONE;
      ST_BCD:  if (k_r == 4'd2) state_nxt = ST_DONE;
      ST_DUMP: if (k_r == x_f) state_nxt = ST_DONE;
      ST_LOAD_RD: state_nxt = ST_LOAD_WR;
      ST_LOAD_WR: state_nxt = (k_r == x_f) ? ST_DONE : ST_LOAD_RD;
      ST_DRAW_RD: state_nxt = ST_DRAW_LINE;
      ST_DRAW_LINE: state_nxt = (py >= 9'(SCREEN_HEIGHT)) ?
                                ((k_r == n_f - 4'd1) ? ST_DONE : ST_DRAW_RD) : ST_DRAW_PIX;
      ST_DRAW_PIX: begin
        if (px < 9'(SCREEN_WIDTH) && line_r[3'd7 - c_r]) state_nxt = ST_DRAW_WR;
        else if (c_r == 3'd7)
          state_nxt = (k_r == n_f - 4'd1) ? ST_DONE : ST_DRAW_RD;
      end
      ST_DRAW_WR: state_nxt = (c_r == 3'd7) ?
                  ((k_r == n_f - 4'd1) ? ST_DONE : ST_DRAW_RD) : ST_DRAW_PIX;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    m_we = 1'b0; m_addr = '0; m_wd = 8'd0;
    s_we = 1'b0; s_addr = pidx_r; s_wd = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        m_we = 1'b1; m_addr = cnt_r[AW-1:0];
        s_we = 1'b1; s_addr = cnt_r[PW-1:0];
      end
      ST_IDLE: begin
        m_addr = AW'(in_address);
        m_we   = in_acc && (in_operation == OP_WRITE);
        m_wd   = in_write_data;
        s_addr = PW'(in_address);
      end
      ST_FETCH_HI: m_addr = AW'(pc_r);
      ST_FETCH_LO: m_addr = AW'(pc_r + 12'd1);
      ST_SCLR: begin s_we = 1'b1; s_addr = pidx_r; end
      ST_BCD: begin
        m_we = 1'b1; m_addr = AW'(i_k);
        m_wd = (k_r == 4'd0) ? bcd_h : (k_r == 4'd1) ? bcd_t : bcd_o;
      end
      ST_DUMP:    begin m_we = 1'b1; m_addr = AW'(i_k); m_wd = v_r[k_r]; end
      ST_LOAD_RD: m_addr = AW'(i_k);
      ST_DRAW_RD: m_addr = AW'(i_k);
      ST_DRAW_PIX: s_addr = pix_a[PW-1:0];
      ST_DRAW_WR: begin s_we = 1'b1; s_addr = pidx_r; s_wd = ~s_rd; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR; cnt_r <= '0; ovalid_r <= 1'b0;
      pc_r <= PC_START; sp_r <= '0; i_r <= '0; dt_r <= '0; st_r <= '0;
      for (int j = 0; j < 16; j++) v_r[j] <= 8'd0;
      for (int j = 0; j < STACK_DEPTH; j++) stk_r[j] <= 12'd0;
    end else begin
      state_r <= state_nxt;
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      case (state_r)
        ST_CLEAR: cnt_r <= cnt_r + 1'b1;
        ST_IDLE: if (in_acc) begin
          addr_r <= in_address;
          key_r <= in_key_code; rnd_r <= in_random_byte;
          rd_r <= 8'd0; fl_r <= '0; k_r <= 4'd0; pidx_r <= '0;
        end
        ST_MREAD: rd_r <= m_rd;
        ST_PX_RD: rd_r <= ({20'd0, addr_r} < 32'(PIX)) ? {7'd0, s_rd} : 8'd0;
        ST_FETCH_LO: hi_r <= m_rd;
        ST_DECODE:   lo_r <= m_rd;
        ST_EXEC: begin
          pc_r <= pc_r + 12'd2;
          case (hi_r[7:4])
            4'h0: if (x_f == 4'h0 && lo_r == 8'hE0) fl_r.drawn <= 1'b1;
                  else if (x_f == 4'h0 && lo_r == 8'hEE) begin
                    if (sp_r == '0 || sp_r > SPW'(STACK_DEPTH)) fl_r.fault <= 1'b1;
                    else begin
                      sp_r <= sp_r - 1'b1;
                      pc_r <= stk_r[SIW'(sp_r - 1'b1)];
                    end
                  end
            4'h1: pc_r <= nnn;
            4'h2: if (sp_r >= SPW'(STACK_DEPTH)) fl_r.fault <= 1'b1;
                  else begin
                    stk_r[SIW'(sp_r)] <= pc_r + 12'd2;
                    sp_r <= sp_r + 1'b1; pc_r <= nnn;
                  end
            4'h3: if (va == lo_r) pc_r <= pc_r + 12'd4;
            4'h4: if (va != lo_r) pc_r <= pc_r + 12'd4;
            4'h5: if (va == vb) pc_r <= pc_r + 12'd4;
            4'h6: v_r[x_f] <= lo_r;
            4'h7: v_r[x_f] <= va + lo_r;
            4'h8: case (n_f)
              4'h0: v_r[x_f] <= vb;
              4'h1: v_r[x_f] <= va | vb;
              4'h2: v_r[x_f] <= va & vb;
              4'h3: v_r[x_f] <= va ^ vb;
              4'h4: begin v_r[x_f] <= va + vb;
                          v_r[15] <= {7'd0, ({1'b0, va} + {1'b0, vb}) > 9'd255}; end
              4'h5: begin v_r[x_f] <= va - vb; v_r[15] <= {7'd0, va >= vb}; end
              4'h6: begin v_r[x_f] <= va >> 1; v_r[15] <= {7'd0, va[0]}; end
              4'h7: begin v_r[x_f] <= vb - va; v_r[15] <= {7'd0, vb >= va}; end
              4'hE: begin v_r[x_f] <= va << 1; v_r[15] <= {7'd0, va[7]}; end
              default: ;
            endcase
            4'h9: if (va != vb) pc_r <= pc_r + 12'd4;
            4'hA: i_r <= {4'd0, nnn};
            4'hB: pc_r <= {4'd0, v_r[0]} + nnn;
            4'hC: v_r[x_f] <= rnd_r & lo_r;
            4'hD: begin
              x0_r <= va; y0_r <= vb; v_r[15] <= 8'd0; fl_r.drawn <= 1'b1;
            end
            4'hE: if (lo_r == 8'h9E) begin
                    if (key_ok && va == {3'd0, key_r}) pc_r <= pc_r + 12'd4;
                  end else if (lo_r == 8'hA1) begin
                    if (!(key_ok && va == {3'd0, key_r})) pc_r <= pc_r + 12'd4;
                  end
            default: case (lo_r)
              8'h07: v_r[x_f] <= dt_r;
              8'h0A: if (key_ok) v_r[x_f] <= {3'd0, key_r};
                     else begin pc_r <= pc_r; fl_r.waiting <= 1'b1; end
              8'h15: dt_r <= va;
              8'h18: st_r <= va;
              8'h1E: i_r <= i_r + {8'd0, va};
              8'h29: i_r <= {8'd0, va} * 16'd5;
              default: ;
            endcase
          endcase
        end
        ST_SCLR: pidx_r <= pidx_r + 1'b1;
        ST_BCD, ST_DUMP: k_r <= k_r + 4'd1;
        ST_LOAD_WR: begin v_r[k_r] <= m_rd; k_r <= k_r + 4'd1; end
        ST_DRAW_LINE: begin
          line_r <= m_rd; c_r <= 3'd0;
          if (py >= 9'(SCREEN_HEIGHT)) k_r <= k_r + 4'd1;
        end
        ST_DRAW_PIX: begin
          pidx_r <= s_addr;
          if (!(px < 9'(SCREEN_WIDTH) && line_r[3'd7 - c_r])) begin
            c_r <= c_r + 3'd1;
            if (c_r == 3'd7) k_r <= k_r + 4'd1;
          end
        end
        ST_DRAW_WR: begin
          if (s_rd) v_r[15] <= 8'd1;
          c_r <= c_r + 3'd1;
          if (c_r == 3'd7) k_r <= k_r + 4'd1;
        end
        ST_DONE: ovalid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_program_counter = pc_r;
  assign out_read_data       = rd_r;
  assign out_screen_drawn    = fl_r.drawn;
  assign out_awaiting_key    = fl_r.waiting;
  assign out_stack_fault     = fl_r.fault;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("accept while busy");
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH)) else $error("stack pointer out of range");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> out_valid) else $error("result lost");
`endif
endmodule

FILE: design/bvm_mem.sv
// ----------------------------------------------------------------------------
// bvm_mem
// Single-port byte memory with registered read data.
// ----------------------------------------------------------------------------
module bvm_mem #(
  parameter int DEPTH = bvm_pkg::MEM_BYTES_D,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the byte-code VM executor. Requests write and read
// memory, read pixels and run instructions placed at the program counter.
// Every request is predicted and each result is compared field by field.
// ----------------------------------------------------------------------------
module testbench;
  import bvm_pkg::*;

  localparam int LIMIT = 20000000;

  localparam logic [3:0] G_SYS  = 4'h0;
  localparam logic [3:0] G_JP   = 4'h1;
  localparam logic [3:0] G_CALL = 4'h2;
  localparam logic [3:0] G_ALU  = 4'h8;
  localparam logic [3:0] G_JPV0 = 4'hB;
  localparam logic [3:0] G_DRW  = 4'hD;
  localparam logic [3:0] G_KEY  = 4'hE;
  localparam logic [3:0] G_MISC = 4'hF;

  localparam logic [7:0] LO_CLS  = 8'hE0;
  localparam logic [7:0] LO_RET  = 8'hEE;
  localparam logic [7:0] LO_SKP  = 8'h9E;
  localparam logic [7:0] LO_SKNP = 8'hA1;
  localparam logic [7:0] LO_GDT  = 8'h07;
  localparam logic [7:0] LO_WKEY = 8'h0A;
  localparam logic [7:0] LO_SDT  = 8'h15;
  localparam logic [7:0] LO_SST  = 8'h18;
  localparam logic [7:0] LO_ADDI = 8'h1E;
  localparam logic [7:0] LO_FONT = 8'h29;
  localparam logic [7:0] LO_BCD  = 8'h33;
  localparam logic [7:0] LO_DUMP = 8'h55;
  localparam logic [7:0] LO_LOAD = 8'h65;

  typedef struct {
    logic [11:0] pc;
    logic [7:0]  rd;
    logic        drawn;
    logic        waiting;
    logic        fault;
  } vm_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic [11:0] in_address;
  logic [7:0]  in_write_data;
  logic [4:0]  in_key_code;
  logic [7:0]  in_random_byte;
  logic        out_valid;
  logic        out_stall;
  logic [11:0] out_program_counter;
  logic [7:0]  out_read_data;
  logic        out_screen_drawn;
  logic        out_awaiting_key;
  logic        out_stack_fault;

  byte_vm_instruction_executor_top dut (.*);

  logic [7:0]  vm_mem [4096];
  logic [7:0]  vm_reg [16];
  logic [11:0] vm_stack [16];
  logic [4:0]  vm_sp;
  logic [11:0] vm_pc;
  logic [15:0] vm_idx;
  logic [7:0]  vm_dt;
  logic [7:0]  vm_st;
  logic        vm_scr [2048];

  vm_result_t pending_q[$];
  int errors;
  int sent;
  int checked;
  int faults_seen;
  int draws_seen;
  int cycles;
  int send_idle;
  int recv_idle;
  int hold_left;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    vm_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      checked++;
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected, pc %h", $time, out_program_counter);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_program_counter !== e.pc) begin
          $display("%0t: pc expected %h actual %h", $time, e.pc, out_program_counter);
          errors++;
        end
        if (out_read_data !== e.rd) begin
          $display("%0t: read_data expected %h actual %h", $time, e.rd, out_read_data);
          errors++;
        end
        if (out_screen_drawn !== e.drawn) begin
          $display("%0t: screen_drawn expected %b actual %b", $time, e.drawn,
                   out_screen_drawn);
          errors++;
        end
        if (out_awaiting_key !== e.waiting) begin
          $display("%0t: awaiting_key expected %b actual %b", $time, e.waiting,
                   out_awaiting_key);
          errors++;
        end
        if (out_stack_fault !== e.fault) begin
          $display("%0t: stack_fault expected %b actual %b", $time, e.fault,
                   out_stack_fault);
          errors++;
        end
      end
    end
  end

  task automatic step_pc();
    vm_pc = vm_pc + 12'd2;
  endtask

  task automatic vm_draw(input logic [3:0] x, input logic [3:0] y, input logic [3:0] n);
    int x0;
    int y0;
    int px;
    int py;
    logic [7:0] line;
    x0 = vm_reg[x];
    y0 = vm_reg[y];
    vm_reg[15] = 8'd0;
    for (int r = 0; r < n; r++) begin
      py = y0 + r;
      line = vm_mem[12'(vm_idx + r)];
      if (py < 32) begin
        for (int c = 0; c < 8; c++) begin
          px = x0 + c;
          if (px < 64 && line[7-c]) begin
            if (vm_scr[py*64+px]) vm_reg[15] = 8'd1;
            vm_scr[py*64+px] = !vm_scr[py*64+px];
          end
        end
      end
    end
  endtask

  task automatic vm_execute(input logic [4:0] key, input logic [7:0] rnd,
                            inout vm_result_t r);
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  va;
    logic [7:0]  vb;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [11:0] nnn;
    logic        kv;
    logic        flag;
    hi = vm_mem[vm_pc];
    lo = vm_mem[vm_pc + 12'd1];
    x = hi[3:0];
    y = lo[7:4];
    nnn = {x, lo};
    va = vm_reg[x];
    vb = vm_reg[y];
    kv = (key < 5'd16);
    case (hi[7:4])
      G_SYS: begin
        if (lo == LO_CLS && x == 4'd0) begin
          foreach (vm_scr[i]) vm_scr[i] = 1'b0;
          r.drawn = 1'b1;
          step_pc();
        end else if (lo == LO_RET && x == 4'd0) begin
          if (vm_sp == 5'd0) begin
            r.fault = 1'b1;
            step_pc();
          end else begin
            vm_sp = vm_sp - 5'd1;
            vm_pc = vm_stack[vm_sp];
          end
        end else begin
          step_pc();
        end
      end
      G_JP: vm_pc = nnn;
      G_CALL: begin
        if (vm_sp >= 5'd16) begin
          r.fault = 1'b1;
          step_pc();
        end else begin
          vm_stack[vm_sp] = vm_pc + 12'd2;
          vm_sp = vm_sp + 5'd1;
          vm_pc = nnn;
        end
      end
      4'h3: begin step_pc(); if (va == lo) step_pc(); end
      4'h4: begin step_pc(); if (va != lo) step_pc(); end
      4'h5: begin step_pc(); if (va == vb) step_pc(); end
      4'h6: begin vm_reg[x] = lo; step_pc(); end
      4'h7: begin vm_reg[x] = va + lo; step_pc(); end
      G_ALU: begin
        case (lo[3:0])
          4'h0: vm_reg[x] = vb;
          4'h1: vm_reg[x] = va | vb;
          4'h2: vm_reg[x] = va & vb;
          4'h3: vm_reg[x] = va ^ vb;
          4'h4: begin
            flag = ({1'b0, va} + {1'b0, vb}) > 9'd255;
            vm_reg[x] = va + vb;
            vm_reg[15] = {7'd0, flag};
          end
          4'h5: begin
            flag = va >= vb;
            vm_reg[x] = va - vb;
            vm_reg[15] = {7'd0, flag};
          end
          4'h6: begin
            vm_reg[x] = va >> 1;
            vm_reg[15] = {7'd0, va[0]};
          end
          4'h7: begin
            flag = vb >= va;
            vm_reg[x] = vb - va;
            vm_reg[15] = {7'd0, flag};
          end
          4'hE: begin
            vm_reg[x] = va << 1;
            vm_reg[15] = {7'd0, va[7]};
          end
          default: ;
        endcase
        step_pc();
      end
      4'h9: begin step_pc(); if (va != vb) step_pc(); end
      4'hA: begin vm_idx = {4'd0, nnn}; step_pc(); end
      G_JPV0: vm_pc = 12'({4'd0, vm_reg[0]} + nnn);
      4'hC: begin vm_reg[x] = rnd & lo; step_pc(); end
      G_DRW: begin
        vm_draw(x, y, lo[3:0]);
        r.drawn = 1'b1;
        step_pc();
      end
      G_KEY: begin
        step_pc();
        if (lo == LO_SKP) begin
          if (kv && va == {3'd0, key}) step_pc();
        end else if (lo == LO_SKNP) begin
          if (!(kv && va == {3'd0, key})) step_pc();
        end
      end
      default: begin
        case (lo)
          LO_GDT: begin vm_reg[x] = vm_dt; step_pc(); end
          LO_WKEY: begin
            if (kv) begin
              vm_reg[x] = {3'd0, key};
              step_pc();
            end else begin
              r.waiting = 1'b1;
            end
          end
          LO_SDT: begin vm_dt = va; step_pc(); end
          LO_SST: begin vm_st = va; step_pc(); end
          LO_ADDI: begin vm_idx = vm_idx + va; step_pc(); end
          LO_FONT: begin vm_idx = 16'(va * 5); step_pc(); end
          LO_BCD: begin
            vm_mem[12'(vm_idx)] = va / 100;
            vm_mem[12'(vm_idx + 1)] = (va % 100) / 10;
            vm_mem[12'(vm_idx + 2)] = va % 10;
            step_pc();
          end
          LO_DUMP: begin
            for (int k = 0; k <= x; k++) vm_mem[12'(vm_idx + k)] = vm_reg[k];
            step_pc();
          end
          LO_LOAD: begin
            for (int k = 0; k <= x; k++) vm_reg[k] = vm_mem[12'(vm_idx + k)];
            step_pc();
          end
          default: step_pc();
        endcase
      end
    endcase
  endtask

  task automatic vm_predict(input logic [1:0] op, input logic [11:0] a,
                            input logic [7:0] wd, input logic [4:0] key,
                            input logic [7:0] rnd);
    vm_result_t r;
    r.rd = 8'd0;
    r.drawn = 1'b0;
    r.waiting = 1'b0;
    r.fault = 1'b0;
    case (op)
      OP_WRITE: vm_mem[a] = wd;
      OP_READ:  r.rd = vm_mem[a];
      OP_PIXEL: r.rd = (a < 12'd2048) ? {7'd0, vm_scr[a]} : 8'd0;
      default:  vm_execute(key, rnd, r);
    endcase
    r.pc = vm_pc;
    if (r.fault) faults_seen++;
    if (r.drawn) draws_seen++;
    pending_q.push_back(r);
  endtask

  task automatic send_request(input logic [1:0] op, input logic [11:0] a,
                              input logic [7:0] wd, input logic [4:0] key,
                              input logic [7:0] rnd);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_address <= a;
    in_write_data <= wd;
    in_key_code <= key;
    in_random_byte <= rnd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    vm_predict(op, a, wd, key, rnd);
    sent++;
  endtask

  task automatic run_instr(input logic [15:0] word, input logic [4:0] key,
                           input logic [7:0] rnd);
    send_request(OP_WRITE, vm_pc, word[15:8], 5'($urandom), 8'($urandom));
    send_request(OP_WRITE, vm_pc + 12'd1, word[7:0], 5'($urandom), 8'($urandom));
    send_request(OP_EXEC, 12'($urandom), 8'($urandom), key, rnd);
  endtask

  function automatic logic [15:0] random_instr();
    logic [3:0] g;
    logic [3:0] x;
    logic [7:0] lo;
    g = 4'($urandom);
    x = 4'($urandom);
    lo = 8'($urandom);
    case (g)
      G_SYS: begin
        case ($urandom_range(9))
          0: begin x = 4'd0; lo = LO_CLS; end
          1, 2, 3, 4: begin x = 4'd0; lo = LO_RET; end
          default: ;
        endcase
      end
      G_ALU: if ($urandom_range(3) != 0) lo[3:0] = 4'($urandom_range(7));
      G_DRW: if ($urandom_range(3) != 0) lo[3:0] = 4'($urandom_range(5));
      G_KEY: begin
        case ($urandom_range(2))
          0: lo = LO_SKP;
          1: lo = LO_SKNP;
          default: ;
        endcase
      end
      G_MISC: begin
        case ($urandom_range(10))
          0: lo = LO_GDT;
          1: lo = LO_WKEY;
          2: lo = LO_SDT;
          3: lo = LO_SST;
          4: lo = LO_ADDI;
          5: lo = LO_FONT;
          6: lo = LO_BCD;
          7: lo = LO_DUMP;
          8: lo = LO_LOAD;
          default: ;
        endcase
      end
      default: ;
    endcase
    return {g, x, lo};
  endfunction

  function automatic logic [4:0] random_key();
    if ($urandom_range(3) == 0) return 5'($urandom_range(31, 16));
    if ($urandom_range(1) == 0) return 5'($urandom_range(15));
    return vm_reg[$urandom_range(15)][4:0];
  endfunction

  task automatic test_memory();
    send_request(OP_WRITE, 12'h000, 8'hFF, 5'd0, 8'h00);
    send_request(OP_WRITE, 12'hFFF, 8'hA5, 5'd31, 8'hFF);
    send_request(OP_READ, 12'h000, 8'h00, 5'd0, 8'h00);
    send_request(OP_READ, 12'hFFF, 8'h00, 5'd0, 8'h00);
    send_request(OP_PIXEL, 12'hFFF, 8'h00, 5'd0, 8'h00);
  endtask

  task automatic test_instructions();
    run_instr({G_SYS, 4'h0, LO_RET}, 5'd0, 8'h00);
    run_instr(16'h60FF, 5'd0, 8'h00);
    run_instr(16'h6F3E, 5'd0, 8'h00);
    run_instr(16'hD0F3, 5'd0, 8'h00);
    run_instr(16'h8F07, 5'd0, 8'h00);
    run_instr({G_MISC, 4'h4, LO_WKEY}, 5'd16, 8'h00);
    send_request(OP_PIXEL, 12'd0, 8'h00, 5'd0, 8'h00);
    run_instr({G_JPV0, 12'hFFF}, 5'd0, 8'h00);
  endtask

  task automatic test_stack();
    repeat (17) run_instr({G_CALL, vm_pc + 12'd2}, random_key(), 8'($urandom));
    repeat (17) run_instr({G_SYS, 4'h0, LO_RET}, random_key(), 8'($urandom));
  endtask

  task automatic test_random(input int count);
    int stop;
    stop = sent + count;
    while (sent < stop) begin
      case ($urandom_range(99)) inside
        [0:69]:  run_instr(random_instr(), random_key(), 8'($urandom));
        [70:79]: send_request(OP_WRITE, 12'($urandom), 8'($urandom), 5'($urandom),
                              8'($urandom));
        [80:87]: send_request(OP_READ, 12'($urandom), 8'($urandom), 5'($urandom),
                              8'($urandom));
        [88:95]: send_request(OP_PIXEL, 12'($urandom_range($urandom_range(1) ? 2047 : 4095)),
                              8'($urandom), 5'($urandom), 8'($urandom));
        default: send_request(OP_EXEC, 12'($urandom), 8'($urandom), random_key(),
                              8'($urandom));
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_left = 400;
    send_idle = 0;
    repeat (4) run_instr(random_instr(), random_key(), 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    foreach (vm_mem[i]) vm_mem[i] = 8'd0;
    foreach (vm_reg[i]) vm_reg[i] = 8'd0;
    foreach (vm_stack[i]) vm_stack[i] = 12'd0;
    foreach (vm_scr[i]) vm_scr[i] = 1'b0;
    vm_sp = 5'd0;
    vm_pc = PC_START;
    vm_idx = 16'd0;
    vm_dt = 8'd0;
    vm_st = 8'd0;
    errors = 0;
    sent = 0;
    checked = 0;
    faults_seen = 0;
    draws_seen = 0;
    cycles = 0;
    hold_left = 0;
    send_idle = 23;
    recv_idle = 70;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_operation <= OP_WRITE;
    in_address <= 12'd0;
    in_write_data <= 8'd0;
    in_key_code <= 5'd0;
    in_random_byte <= 8'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_memory();
    test_instructions();
    test_stack();
    test_random(200);
    send_idle = 70;
    recv_idle = 23;
    test_random(200);
    send_idle = 0;
    recv_idle = 0;
    test_random(200);
    test_backpressure();
    drain();
    $display("covered %0d requests, %0d results checked", sent, checked);
    $display("draw or clear results %0d, stack faults %0d", draws_seen, faults_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
